### rtl/bad_pkg.sv
// shared types, constants and helpers of the box area downscaler
package bad_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int DIM_W      = 13;
   localparam int POS_W      = 12;
   localparam int SUM_W      = 40;
   localparam int AREA_W     = 25;
   localparam int MAX_COLS   = 4096;
   localparam int DIV_NW     = 41;
   localparam int DIV_DW     = 25;
   localparam int DIV_CW     = 6;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;
   localparam int CSR_AW     = 2;

   localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   // configuration register indexes
   typedef enum logic [CSR_AW-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_MAX_SIDE   = 2'd2
   } csr_idx_type;

   // finished block handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0]  red_sum;
      logic [SUM_W-1:0]  green_sum;
      logic [SUM_W-1:0]  blue_sum;
      logic [AREA_W-1:0] area;
      logic              row_end;
      logic              frame_end;
   } blk_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_SETUP,
      FR_DIVW,
      FR_DIVH,
      FR_DIVX,
      FR_DIVY,
      FR_RUN
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_LOAD
   } back_state_type;

   // zero reads as one, anything above the frame limit saturates
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > MAX_DIM) r = MAX_DIM;
      else r = v;
      return r;
   endfunction

endpackage

### rtl/box_area_downscale.sv
// top level of the box area downscaler
//
// Pixels enter on the req_ stream one transfer at a time in raster order and
// averaged pixels leave on the rsp_ stream. csr_ writes set source width,
// height and target longest side; they apply from the next frame start.
// At a frame's first pixel the front derives the output size: directly in
// pass through, else by four divisions of 41 quotient bits, with req_tready
// held low. Inside a frame the front takes one pixel per cycle while the
// queue has room and keeps per-column partial sums in a 4096-entry store.
// Each finished block goes through a 4-entry queue to the back, where an area
// of one goes straight to the result register and a larger area through the
// iterative dividers, which set the result rate; when the queue holds more
// than two blocks the front holds req_tready low. A pass-through pixel goes
// through the accumulate stage, the queue and the result register. A stalled
// receiver holds the result register and the queue backs up into the front.
// Reset clears control state and restores width 1, height 1, pass through.
module box_area_downscale (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red_in, green_in, blue_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red_out, green_out, blue_out
   output logic        rsp_tlast,   // row_end
   output logic        rsp_tuser    // frame_end
);
   import bad_pkg::*;

   logic               push, pop, fifo_empty;
   blk_type            push_data, pop_data;
   logic [FIFO_CW-1:0] fifo_count;

   bad_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .fifo_count (fifo_count),
      .push       (push),
      .push_data  (push_data)
   );

   bad_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (fifo_empty),
      .count     (fifo_count)
   );

   bad_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_data  (pop_data),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/bad_div.sv
// iterative restoring divider, one quotient bit per cycle
module bad_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bad_pkg::DIV_NW-1:0] num,
   input  logic [bad_pkg::DIV_DW-1:0] den,
   output logic                      done,
   output logic [bad_pkg::DIV_NW-1:0] quo,
   output logic [bad_pkg::DIV_DW-1:0] rem
);
   import bad_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW:0]   shift, diff;
   logic              ge;

   // one shift and trial subtract per cycle
   always_comb begin
      shift = {rem_ff, quo_ff[DIV_NW-1]};
      diff  = shift - {1'b0, den_ff};
      ge    = shift >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DW-1:0] : shift[DIV_DW-1:0];
         quo_in = {quo_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_ff + DIV_CW'(1);
         if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

### rtl/bad_front.sv
// front end: config, frame setup, pixel tracking and per-column block sums
module bad_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [bad_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [bad_pkg::DIM_W-1:0]   csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [47:0]                 req_tdata,
   input  logic [bad_pkg::FIFO_CW-1:0] fifo_count,
   output logic                        push,
   output bad_pkg::blk_type            push_data
);
   import bad_pkg::*;

   front_state_type state_ff, state_in;

   logic [DIM_W-1:0] src_w_ff, src_h_ff, max_side_ff;
   logic [DIM_W-1:0] fw_ff, fh_ff, long_ff, ms_ff;
   logic             pass_ff;
   logic [DIM_W-1:0] ow_ff, oh_ff, xq_ff, xr_ff, yq_ff, yr_ff;
   logic [DIM_W-1:0] x0_ff, x1_ff, xrem_ff, y0_ff, y1_ff, yrem_ff;
   logic [POS_W-1:0] oc_ff, orow_ff, sx_ff, sy_ff;

   // second stage of pixel work
   logic                           b_vld_ff, byp_ff;
   logic [2:0][SAMPLE_W-1:0]       b_pix_ff;
   logic                           b_seg_start_ff, b_first_row_ff, b_seg_end_ff, b_emit_ff;
   logic                           b_pass_ff, b_re_ff, b_fe_ff;
   logic [POS_W-1:0]               b_oc_ff;
   logic [DIM_W-1:0]               b_bw_ff, b_bh_ff;
   logic [2:0][SUM_W-1:0]          acc_ff, acc_in, base;
   logic [3*SUM_W-1:0]             rd_ff;
   logic [3*SUM_W-1:0]             sum_mem [MAX_COLS];
   logic [2*DIM_W-1:0]             area_full;

   // divider hookup
   logic              div_start, div_done;
   logic [DIV_NW-1:0] div_num, div_quo;
   logic [DIV_DW-1:0] div_den, div_rem;
   logic [DIM_W-1:0]  side;
   logic [2*DIM_W-1:0] mul_prod;
   logic [2*DIM_W:0]  dim_num;
   logic [DIM_W-1:0]  quo_dim;

   logic             accept;
   logic             last_col, last_row, seg_end, blk_row_end, col_wrap, row_wrap;
   logic [DIM_W:0]   xsum, ysum;
   logic             xcarry, ycarry;
   logic [DIM_W-1:0] fw_new, fh_new, long_new;
   logic             wr_mem;

   bad_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff    <= DIM_W'(1);
         src_h_ff    <= DIM_W'(1);
         max_side_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_SRC_WIDTH:  src_w_ff    <= csr_wdata;
            CSR_SRC_HEIGHT: src_h_ff    <= csr_wdata;
            CSR_MAX_SIDE:   max_side_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame geometry seen at the first pixel
   always_comb begin
      fw_new   = clamp_dim(src_w_ff);
      fh_new   = clamp_dim(src_h_ff);
      long_new = (fw_new > fh_new) ? fw_new : fh_new;
   end

   // output side numerator: 2*side*max_side + longest
   always_comb begin
      side     = (state_ff == FR_SETUP) ? fw_ff : fh_ff;
      mul_prod = (2*DIM_W)'(side) * (2*DIM_W)'(ms_ff);
      dim_num  = {mul_prod, 1'b0} + (2*DIM_W+1)'(long_ff);
      quo_dim  = (div_quo == '0) ? DIM_W'(1) : div_quo[DIM_W-1:0];
   end

   // position and block boundary tests
   always_comb begin
      last_col    = ({1'b0, sx_ff} + DIM_W'(1)) == fw_ff;
      last_row    = ({1'b0, sy_ff} + DIM_W'(1)) == fh_ff;
      seg_end     = ({1'b0, sx_ff} + DIM_W'(1)) == x1_ff;
      blk_row_end = ({1'b0, sy_ff} + DIM_W'(1)) == y1_ff;
      col_wrap    = ({1'b0, oc_ff} + DIM_W'(1)) == ow_ff;
      row_wrap    = ({1'b0, orow_ff} + DIM_W'(1)) == oh_ff;
      xsum        = {1'b0, xrem_ff} + {1'b0, xr_ff};
      xcarry      = xsum >= {1'b0, ow_ff};
      ysum        = {1'b0, yrem_ff} + {1'b0, yr_ff};
      ycarry      = ysum >= {1'b0, oh_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE:  if (req_tvalid) state_in = FR_SETUP;
         FR_SETUP: state_in = pass_ff ? FR_RUN : FR_DIVW;
         FR_DIVW:  if (div_done) state_in = FR_DIVH;
         FR_DIVH:  if (div_done) state_in = FR_DIVX;
         FR_DIVX:  if (div_done) state_in = FR_DIVY;
         FR_DIVY:  if (div_done) state_in = FR_RUN;
         FR_RUN:   if (accept && last_col && last_row) state_in = FR_IDLE;
         default:  state_in = FR_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      div_start  = 1'b0;
      div_num    = DIV_NW'(dim_num);
      div_den    = DIV_DW'({long_ff, 1'b0});
      req_tready = 1'b0;
      unique case (state_ff)
         FR_SETUP: div_start = !pass_ff;
         FR_DIVW:  div_start = div_done;
         FR_DIVH: begin
            div_start = div_done;
            div_num   = DIV_NW'(fw_ff);
            div_den   = DIV_DW'(ow_ff);
         end
         FR_DIVX: begin
            div_start = div_done;
            div_num   = DIV_NW'(fh_ff);
            div_den   = DIV_DW'(oh_ff);
         end
         FR_RUN:  req_tready = fifo_count <= FIFO_CW'(FIFO_DEPTH - 2);
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         sx_ff    <= '0;
         sy_ff    <= '0;
         b_vld_ff <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         b_vld_ff <= accept;
         byp_ff   <= accept && wr_mem && (oc_ff == b_oc_ff);
         if (accept) begin
            if (last_col) begin
               sx_ff <= '0;
               sy_ff <= last_row ? '0 : sy_ff + POS_W'(1);
            end else begin
               sx_ff <= sx_ff + POS_W'(1);
            end
         end
      end
   end

   // frame setup and output block walk
   always_ff @(posedge clock) begin
      if (state_ff == FR_IDLE && req_tvalid) begin
         fw_ff   <= fw_new;
         fh_ff   <= fh_new;
         long_ff <= long_new;
         ms_ff   <= max_side_ff;
         pass_ff <= (max_side_ff == '0) || (long_new <= max_side_ff);
      end
      if (state_ff == FR_SETUP) begin
         ow_ff <= fw_ff;
         oh_ff <= fh_ff;
      end
      if (state_ff == FR_DIVW && div_done) ow_ff <= quo_dim;
      if (state_ff == FR_DIVH && div_done) oh_ff <= quo_dim;
      if (state_ff == FR_DIVX && div_done) begin
         xq_ff <= div_quo[DIM_W-1:0];
         xr_ff <= div_rem[DIM_W-1:0];
      end
      if (state_ff == FR_DIVY && div_done) begin
         yq_ff   <= div_quo[DIM_W-1:0];
         yr_ff   <= div_rem[DIM_W-1:0];
         oc_ff   <= '0;
         orow_ff <= '0;
         x0_ff   <= '0;
         x1_ff   <= xq_ff;
         xrem_ff <= xr_ff;
         y0_ff   <= '0;
         y1_ff   <= div_quo[DIM_W-1:0];
         yrem_ff <= div_rem[DIM_W-1:0];
      end
      if (accept && !pass_ff) begin
         if (seg_end) begin
            if (col_wrap) begin
               oc_ff   <= '0;
               x0_ff   <= '0;
               x1_ff   <= xq_ff;
               xrem_ff <= xr_ff;
            end else begin
               oc_ff   <= oc_ff + POS_W'(1);
               x0_ff   <= x1_ff;
               x1_ff   <= x1_ff + xq_ff + DIM_W'(xcarry);
               xrem_ff <= xcarry ? DIM_W'(xsum - {1'b0, ow_ff}) : xsum[DIM_W-1:0];
            end
         end
         if (last_col && blk_row_end) begin
            if (row_wrap) begin
               orow_ff <= '0;
               y0_ff   <= '0;
               y1_ff   <= yq_ff;
               yrem_ff <= yr_ff;
            end else begin
               orow_ff <= orow_ff + POS_W'(1);
               y0_ff   <= y1_ff;
               y1_ff   <= y1_ff + yq_ff + DIM_W'(ycarry);
               yrem_ff <= ycarry ? DIM_W'(ysum - {1'b0, oh_ff}) : ysum[DIM_W-1:0];
            end
         end
      end
   end

   // capture the accepted pixel for the accumulate stage
   always_ff @(posedge clock) begin
      if (accept) begin
         b_pix_ff[0]    <= req_tdata[15:0];
         b_pix_ff[1]    <= req_tdata[31:16];
         b_pix_ff[2]    <= req_tdata[47:32];
         b_seg_start_ff <= {1'b0, sx_ff} == x0_ff;
         b_first_row_ff <= {1'b0, sy_ff} == y0_ff;
         b_seg_end_ff   <= seg_end;
         b_emit_ff      <= seg_end && blk_row_end;
         b_oc_ff        <= oc_ff;
         b_pass_ff      <= pass_ff;
         b_bw_ff        <= x1_ff - x0_ff;
         b_bh_ff        <= y1_ff - y0_ff;
         b_re_ff        <= pass_ff ? last_col : col_wrap;
         b_fe_ff        <= pass_ff ? (last_col && last_row) : (col_wrap && row_wrap);
      end
   end

   // accumulate: restart, resume from the column store, or keep adding
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (!b_seg_start_ff) base[c] = acc_ff[c];
         else if (b_first_row_ff) base[c] = '0;
         else if (byp_ff) base[c] = acc_ff[c];
         else base[c] = rd_ff[c*SUM_W +: SUM_W];
         acc_in[c] = base[c] + SUM_W'(b_pix_ff[c]);
      end
      wr_mem = b_vld_ff && !b_pass_ff && b_seg_end_ff;
   end

   always_ff @(posedge clock) begin
      if (b_vld_ff) acc_ff <= acc_in;
   end

   // column sum store
   always_ff @(posedge clock) begin
      if (wr_mem) sum_mem[b_oc_ff] <= acc_in;
      rd_ff <= sum_mem[oc_ff];
   end

   // hand finished blocks to the queue
   always_comb begin
      area_full = (2*DIM_W)'(b_bw_ff) * (2*DIM_W)'(b_bh_ff);
      push      = b_vld_ff && (b_pass_ff || b_emit_ff);
      if (b_pass_ff) begin
         push_data.red_sum   = SUM_W'(b_pix_ff[0]);
         push_data.green_sum = SUM_W'(b_pix_ff[1]);
         push_data.blue_sum  = SUM_W'(b_pix_ff[2]);
         push_data.area      = AREA_W'(1);
      end else begin
         push_data.red_sum   = acc_in[0];
         push_data.green_sum = acc_in[1];
         push_data.blue_sum  = acc_in[2];
         push_data.area      = area_full[AREA_W-1:0];
      end
      push_data.row_end   = b_re_ff;
      push_data.frame_end = b_fe_ff;
   end

endmodule

### rtl/bad_fifo.sv
// short queue of finished blocks between front and back
module bad_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bad_pkg::blk_type            push_data,
   input  logic                        pop,
   output bad_pkg::blk_type            pop_data,
   output logic                        empty,
   output logic [bad_pkg::FIFO_CW-1:0] count
);
   import bad_pkg::*;

   blk_type            store_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, rd_ff;
   logic [FIFO_CW-1:0] cnt_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + FIFO_AW'(1);
         if (pop) rd_ff <= rd_ff + FIFO_AW'(1);
         cnt_ff <= cnt_ff + FIFO_CW'(push) - FIFO_CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ff] <= push_data;
   end

   assign pop_data = store_ff[rd_ff];
   assign empty    = cnt_ff == '0;
   assign count    = cnt_ff;

endmodule

### rtl/bad_back.sv
// back end: divide block sums by area with rounding, drive the result channel
module bad_back (
   input  logic             clock,
   input  logic             reset,
   input  bad_pkg::blk_type fifo_data,
   input  logic             fifo_empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);
   import bad_pkg::*;

   back_state_type state_ff, state_in;

   logic                     out_vld_ff;
   logic [2:0][SAMPLE_W-1:0] out_pix_ff;
   logic                     out_re_ff, out_fe_ff;
   logic                     ent_re_ff, ent_fe_ff;

   logic                     out_free, area_one;
   logic                     div_start, load_direct, load_div;
   logic [2:0][DIV_NW-1:0]   num;
   logic [2:0][DIV_NW-1:0]   quo;
   logic [2:0][DIV_DW-1:0]   rem;
   logic [2:0]               done;
   logic [2:0][SAMPLE_W-1:0] avg;
   logic [2:0][SUM_W-1:0]    sums;

   assign out_free = !out_vld_ff || rsp_tready;
   assign area_one = fifo_data.area == AREA_W'(1);
   assign sums[0]  = fifo_data.red_sum;
   assign sums[1]  = fifo_data.green_sum;
   assign sums[2]  = fifo_data.blue_sum;

   // one divider per color, rounded by adding half the area
   for (genvar c = 0; c < 3; c++) begin : g_div
      assign num[c] = {1'b0, sums[c]} + DIV_NW'(fifo_data.area >> 1);
      assign avg[c] = (quo[c] > DIV_NW'(SAMPLE_MAX)) ? SAMPLE_MAX : quo[c][SAMPLE_W-1:0];
      bad_div u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .num   (num[c]),
         .den   (fifo_data.area),
         .done  (done[c]),
         .quo   (quo[c]),
         .rem   (rem[c])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!fifo_empty && !area_one) state_in = BK_DIV;
         BK_DIV:  if (done[0]) state_in = BK_LOAD;
         BK_LOAD: if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop         = 1'b0;
      div_start   = 1'b0;
      load_direct = 1'b0;
      load_div    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_empty) begin
               if (area_one) begin
                  load_direct = out_free;
                  pop         = out_free;
               end else begin
                  div_start = 1'b1;
                  pop       = 1'b1;
               end
            end
         end
         BK_LOAD: load_div = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_direct || load_div) out_vld_ff <= 1'b1;
         else if (rsp_tready) out_vld_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (div_start) begin
         ent_re_ff <= fifo_data.row_end;
         ent_fe_ff <= fifo_data.frame_end;
      end
      if (load_direct) begin
         for (int c = 0; c < 3; c++) out_pix_ff[c] <= sums[c][SAMPLE_W-1:0];
         out_re_ff <= fifo_data.row_end;
         out_fe_ff <= fifo_data.frame_end;
      end else if (load_div) begin
         out_pix_ff <= avg;
         out_re_ff  <= ent_re_ff;
         out_fe_ff  <= ent_fe_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_pix_ff[2], out_pix_ff[1], out_pix_ff[0]};
   assign rsp_tlast  = out_re_ff;
   assign rsp_tuser  = out_fe_ff;

endmodule

### verif/tb_box_area_downscale.sv
// testbench of the box area downscaler: directed and random frames checked against a pixel-exact predictor
`timescale 1ns / 1ps

module tb_box_area_downscale;
   import bad_pkg::*;

   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int DRAIN_CYCLES = 250;
   localparam int RANDOM_ITEMS = 1450;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        row_end;
      logic        frame_end;
   } pixel_type;

   // predictor of the downscaler plus queue of expected output pixels
   class downscale_scoreboard;
      longint unsigned reg_w, reg_h, reg_max;
      longint unsigned red_acc[MAX_COLS], green_acc[MAX_COLS], blue_acc[MAX_COLS];
      longint unsigned col, row, out_w, out_h, out_col, out_row;
      longint unsigned bx0, bx1, by0, by1, fw, fh;
      bit pass;
      pixel_type pending[$];
      int errors;

      function new();
         reg_w = 1; reg_h = 1; reg_max = 0;
         col = 0; row = 0; out_w = 0; out_h = 0; out_col = 0; out_row = 0;
         bx0 = 0; bx1 = 0; by0 = 0; by1 = 0; fw = 1; fh = 1; pass = 1; errors = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [12:0] v);
         case (idx)
            CSR_SRC_WIDTH:  reg_w = v;
            CSR_SRC_HEIGHT: reg_h = v;
            CSR_MAX_SIDE:   reg_max = v;
            default: ;
         endcase
      endfunction

      function longint unsigned clip(longint unsigned v);
         return (v == 0) ? 1 : ((v > 4096) ? 4096 : v);
      endfunction

      function longint unsigned scaled(longint unsigned side, longint unsigned longest);
         longint unsigned d;
         d = (2 * side * reg_max + longest) / (2 * longest);
         return (d < 1) ? 1 : d;
      endfunction

      function logic [15:0] mean(longint unsigned s, longint unsigned area);
         longint unsigned v;
         v = (s + area / 2) / area;
         return (v > 65535) ? 16'hffff : v[15:0];
      endfunction

      // note one accepted source pixel
      function void note_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
         longint unsigned longest, sx, sy, area;
         int oc;
         pixel_type p;
         if (col == 0 && row == 0) begin
            fw = clip(reg_w);
            fh = clip(reg_h);
            longest = (fw > fh) ? fw : fh;
            pass = (reg_max == 0) || (longest <= reg_max);
            out_w = pass ? fw : scaled(fw, longest);
            out_h = pass ? fh : scaled(fh, longest);
            out_col = 0; out_row = 0;
            bx0 = 0; bx1 = fw / out_w; by0 = 0; by1 = fh / out_h;
         end
         sx = col;
         sy = row;
         if (pass) begin
            p.red = r; p.green = g; p.blue = b;
            p.row_end = (sx + 1 == fw);
            p.frame_end = (sx + 1 == fw) && (sy + 1 == fh);
            pending.push_back(p);
         end else begin
            oc = (out_col >= MAX_COLS) ? MAX_COLS - 1 : int'(out_col);
            if (sy == by0 && sx == bx0) begin
               red_acc[oc] = r; green_acc[oc] = g; blue_acc[oc] = b;
            end else begin
               red_acc[oc] += r; green_acc[oc] += g; blue_acc[oc] += b;
            end
            if (sx + 1 == bx1 && sy + 1 == by1) begin
               area = (bx1 - bx0) * (by1 - by0);
               if (area == 0) area = 1;
               p.red = mean(red_acc[oc], area);
               p.green = mean(green_acc[oc], area);
               p.blue = mean(blue_acc[oc], area);
               p.row_end = (out_col + 1 == out_w);
               p.frame_end = p.row_end && (out_row + 1 == out_h);
               pending.push_back(p);
            end
            // advance block column
            if (sx + 1 >= bx1) begin
               if (out_col + 1 >= out_w) begin
                  out_col = 0; bx0 = 0; bx1 = fw / out_w;
               end else begin
                  out_col++; bx0 = bx1; bx1 = (out_col + 1) * fw / out_w;
               end
            end
            // advance block row
            if (sx + 1 >= fw && sy + 1 >= by1) begin
               if (out_row + 1 >= out_h) begin
                  out_row = 0; by0 = 0; by1 = fh / out_h;
               end else begin
                  out_row++; by0 = by1; by1 = (out_row + 1) * fh / out_h;
               end
            end
         end
         if (sx + 1 >= fw) begin
            col = 0;
            row = (sy + 1 >= fh) ? 0 : sy + 1;
         end else begin
            col = sx + 1;
         end
      endfunction

      // compare one output transfer with the oldest expected pixel
      function void check_pixel(logic [47:0] d, logic last, logic user);
         pixel_type p;
         if (pending.size() == 0) begin
            $error("unexpected output pixel %h", d);
            errors++;
            return;
         end
         p = pending.pop_front();
         if (d[15:0] !== p.red) begin
            $error("red_out exp %h got %h", p.red, d[15:0]); errors++;
         end
         if (d[31:16] !== p.green) begin
            $error("green_out exp %h got %h", p.green, d[31:16]); errors++;
         end
         if (d[47:32] !== p.blue) begin
            $error("blue_out exp %h got %h", p.blue, d[47:32]); errors++;
         end
         if (last !== p.row_end) begin
            $error("row_end exp %b got %b", p.row_end, last); errors++;
         end
         if (user !== p.frame_end) begin
            $error("frame_end exp %b got %b", p.frame_end, user); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_addr = '0;
   logic [12:0] csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   downscale_scoreboard sb = new();
   int  cycles = 0;
   int  sent = 0;
   bit  calm = 0;
   int  hold_cycles = 0;

   box_area_downscale u_dut (.*);

   always #4 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver with random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 0;
      end else if (hold_cycles > 0) begin
         rsp_tready = 0;
         hold_cycles--;
      end else begin
         rsp_tready = 1;
         if (!calm && $urandom_range(0, 15) == 0) hold_cycles = $urandom_range(1, 12);
      end
   end

   // output transfers
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   task automatic write_csr(csr_idx_type idx, logic [12:0] v);
      @(negedge clock);
      csr_we = 1; csr_addr = idx; csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      sb.write_reg(idx, v);
   endtask

   // wait until every expected pixel is out and the back end has settled
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      int gap;
      @(negedge clock);
      if (!calm && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = {b, g, r};
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(r, g, b);
      sent++;
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // one whole frame at the given settings; kind picks the content pattern
   task automatic run_frame(logic [12:0] w, logic [12:0] h, logic [12:0] ms, int kind);
      int n;
      logic [15:0] v;
      drain();
      write_csr(CSR_SRC_WIDTH, w);
      write_csr(CSR_SRC_HEIGHT, h);
      write_csr(CSR_MAX_SIDE, ms);
      n = int'(sb.clip(w) * sb.clip(h));
      for (int i = 0; i < n; i++) begin
         case (kind)
            0: v = 16'hffff;
            1: v = (i % 2) ? 16'haaaa : 16'h5555;
            2: v = 16'(i & 1);
            default: v = 'x;
         endcase
         if (kind > 2) send_pixel(rand_sample(), rand_sample(), rand_sample());
         else send_pixel(v, ~v, v ^ 16'h0f0f);
      end
      @(negedge clock);
      req_tvalid = 0;
   endtask

   initial begin
      int w, h, ms;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: pass through, extremes, rounding and odd register values
      run_frame(13'd3, 13'd2, 13'd0, 0);
      run_frame(13'd4, 13'd2, 13'd4096, 1);
      run_frame(13'd0, 13'd0, 13'd5, 1);
      run_frame(13'd2, 13'd1, 13'd1, 2);
      run_frame(13'd5, 13'd3, 13'd2, 0);
      run_frame(13'd3, 13'd6, 13'd8191, 3);
      run_frame(13'd700, 13'd0, 13'd1, 0);
      run_frame(13'd1, 13'd300, 13'd3, 3);

      // random frames, mostly small and scaled
      while (sent < RANDOM_ITEMS) begin
         if (sent > RANDOM_ITEMS - 300) calm = 1;
         w = $urandom_range(1, 14);
         h = $urandom_range(1, 14);
         case ($urandom_range(0, 5))
            0: ms = 0;
            1: ms = $urandom_range(15, 8191);
            default: ms = $urandom_range(1, 13);
         endcase
         if ($urandom_range(0, 19) == 0) w = 0;
         run_frame(13'(w), 13'(h), 13'(ms), 3);
      end

      drain();
      if (sb.pending.size() != 0) begin
         $error("%0d expected pixels never came out", sb.pending.size());
         sb.errors++;
      end
      if (sb.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
